>>> hdl/sfht_pkg.sv
package sfht_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_BIN          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_BIN         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_FLAGS       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GROWTH_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BELOW_DEFAULT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_LOW       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_HIGH      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT   = 3'd7;

    typedef struct packed {
        logic acc;
        logic frame;
        logic store;
        logic scan_rd;
        logic scan_step;
        logic setup;
        logic hdec;
        logic fail;
        logic pstart;
        logic idx;
        logic ard;
        logic fac;
        logic mula;
        logic mulb;
        logic kdec;
        logic copy;
        logic nextp;
    } cmd_t;

    typedef struct packed {
        logic align;
        logic scan_eq;
        logic scan_end;
        logic over;
        logic h_low;
        logic k_last;
        logic j_last;
        logic gt;
        logic lt;
        logic k_zero;
        logic have;
        logic p_last;
    } sts_t;

endpackage

>>> hdl/sfht_ram.sv
module sfht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/sfht_ctrl.sv
module sfht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_bin,
    input  sfht_pkg::sts_t    sts,
    output sfht_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_STORE    = 16'h0002,
        S_SCAN_RD  = 16'h0004,
        S_SCAN_CHK = 16'h0008,
        S_SETUP    = 16'h0010,
        S_HRED     = 16'h0020,
        S_PSTART   = 16'h0040,
        S_IDX      = 16'h0080,
        S_ARD      = 16'h0100,
        S_FAC      = 16'h0200,
        S_MULA     = 16'h0400,
        S_MULB     = 16'h0800,
        S_CMP      = 16'h1000,
        S_COPY     = 16'h2000,
        S_NEXTP    = 16'h4000,
        S_DONE     = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                cmd.acc   = start;
                cmd.frame = start & last_bin;
                if (start && last_bin)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = sts.align ? S_SCAN_RD : S_SETUP;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.scan_eq)
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = sts.scan_end ? S_SETUP : S_SCAN_RD;
                end
                else
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_HRED;
            end
            S_HRED:
            begin
                if (sts.over)
                begin
                    if (sts.h_low)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.hdec = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_PSTART;
                end
            end
            S_PSTART:
            begin
                cmd.pstart = 1'b1;
                state_next = S_IDX;
            end
            S_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = S_ARD;
            end
            S_ARD:
            begin
                cmd.ard    = 1'b1;
                state_next = S_FAC;
            end
            S_FAC:
            begin
                cmd.fac    = 1'b1;
                state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mula   = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mulb = 1'b1;
                if (sts.k_last)
                begin
                    state_next = sts.j_last ? S_CMP : S_IDX;
                end
                else
                begin
                    state_next = S_MULA;
                end
            end
            S_CMP:
            begin
                if (!sts.have || sts.gt)
                begin
                    state_next = S_COPY;
                end
                else if (sts.lt || sts.k_zero)
                begin
                    state_next = S_NEXTP;
                end
                else
                begin
                    cmd.kdec = 1'b1;
                end
            end
            S_COPY:
            begin
                cmd.copy   = 1'b1;
                state_next = S_NEXTP;
            end
            S_NEXTP:
            begin
                if (sts.p_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.nextp  = 1'b1;
                    state_next = S_PSTART;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_frame_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_bin) |=> busy)
        else $error("frame close did not start the analysis");
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("controller not idle after a result");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy && !$past(done))
        else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hdl/sfht_dp.sv
module sfht_dp #(
    parameter int HISTORY_LEN   = 1024,
    parameter int MAX_BIN       = 512,
    parameter int MAX_HARMONICS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfht_pkg::cmd_t                      cmd,
    output sfht_pkg::sts_t                      sts,
    input  logic                                cfg_write,
    input  logic [sfht_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfht_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [15:0]                         now_mag,
    input  logic [15:0]                         prior_mag,
    input  logic [9:0]                          bin_number,
    output logic [10:0]                         period_frames,
    output logic                                found,
    output logic [31:0]                         frame_flux
);

    localparam int AW = $clog2(HISTORY_LEN);
    localparam int HW = $clog2(MAX_HARMONICS + 1);
    localparam int KW = $clog2(MAX_HARMONICS);
    localparam int IW = 11 + HW;
    localparam int AX = ((IW > AW) ? IW : AW) + 1;
    localparam int TW = 11 + HW;
    localparam logic [AW:0]   HIST_N  = (AW + 1)'(HISTORY_LEN);
    localparam logic [AX-1:0] HIST_NX = AX'(HISTORY_LEN);
    localparam logic [TW-1:0] HIST_NT = TW'(HISTORY_LEN);
    localparam logic [KW-1:0] K_TOP   = KW'(MAX_HARMONICS - 1);
    localparam logic [HW-1:0] H_MAX   = HW'(MAX_HARMONICS);

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_DEF  = 2'd1,
        SRC_RAM  = 2'd2
    } src_t;

    logic [9:0]  low_bin_reg;
    logic [9:0]  high_bin_reg;
    logic [1:0]  mode_reg;
    logic [31:0] thr_reg;
    logic [31:0] bdef_reg;
    logic [10:0] plo_reg;
    logic [10:0] phi_reg;
    logic [3:0]  hc_reg;

    logic [31:0]   flux_reg;
    logic [AW-1:0] wp_reg;
    logic [AW:0]   fill_reg;
    logic [AW-1:0] start_reg;
    logic [HW-1:0] h_reg;
    logic [HW-1:0] j_reg;
    logic [KW-1:0] k_reg;
    logic [10:0]   p_reg;
    logic [10:0]   top_reg;
    logic          have_reg;
    logic          fail_reg;

    logic [31:0]   frame_reg;
    logic [IW-1:0] idx_reg;
    src_t          src_reg;
    logic          vld_reg;
    logic [31:0]   fac_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   carry_reg;
    logic [MAX_HARMONICS-1:0][31:0] cur_reg;
    logic [MAX_HARMONICS-1:0][31:0] best_reg;
    logic [10:0]   best_p_reg;

    logic          in_range;
    logic [15:0]   diff;
    logic [31:0]   sq;
    logic [31:0]   add_val;
    logic [32:0]   sum_wide;
    logic [31:0]   sum_sat;
    logic [31:0]   stored;
    logic [AX-1:0] aidx;
    src_t          src_next;
    logic [AW-1:0] lk;
    logic [AW:0]   psum;
    logic [AW:0]   paddr;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic [31:0]   rd_eff;
    logic [10:0]   lo_eff;
    logic [10:0]   top_eff;
    logic [HW-1:0] h_clamp;
    logic [TW-1:0] top_h;
    logic [63:0]   mac;

    always_comb
    begin
        in_range = (bin_number >= low_bin_reg) && (bin_number <= high_bin_reg)
                   && (32'(bin_number) <= 32'(MAX_BIN)) && (now_mag > prior_mag);
        diff     = now_mag - prior_mag;
        sq       = 32'(diff) * 32'(diff);
        add_val  = !in_range ? 32'd0 : (mode_reg[0] ? sq : 32'(diff));
        sum_wide = {1'b0, flux_reg} + {1'b0, add_val};
        sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
        stored   = (frame_reg > thr_reg) ? frame_reg : bdef_reg;

        aidx = AX'(idx_reg) + AX'(start_reg);
        if (AX'(idx_reg) >= HIST_NX)
        begin
            src_next = SRC_ZERO;
        end
        else if (aidx >= HIST_NX)
        begin
            src_next = SRC_DEF;
        end
        else
        begin
            src_next = SRC_RAM;
        end

        lk     = cmd.ard ? aidx[AW-1:0] : start_reg;
        psum   = {1'b0, wp_reg} + {1'b0, lk};
        paddr  = (psum >= HIST_N) ? (psum - HIST_N) : psum;
        raddr  = paddr[AW-1:0];
        rd_eff = vld_reg ? rdata : 32'd0;

        lo_eff  = (plo_reg == 11'd0) ? 11'd1 : plo_reg;
        top_eff = (phi_reg > lo_eff) ? phi_reg : lo_eff;
        if (hc_reg < 4'd2)
        begin
            h_clamp = HW'(2);
        end
        else if (32'(hc_reg) > 32'(MAX_HARMONICS))
        begin
            h_clamp = H_MAX;
        end
        else
        begin
            h_clamp = HW'(hc_reg);
        end
        top_h = TW'(top_reg) * TW'(h_reg);
        mac   = prod_reg + {32'd0, carry_reg};
    end

    always_comb
    begin
        sts.align    = mode_reg[1];
        sts.scan_eq  = (rd_eff == bdef_reg);
        sts.scan_end = ({1'b0, start_reg} + 1'b1) >= (HIST_N - 2'd2);
        sts.over     = (top_h >= HIST_NT);
        sts.h_low    = (h_reg <= HW'(2));
        sts.k_last   = (k_reg == K_TOP);
        sts.j_last   = (j_reg == h_reg);
        sts.gt       = (cur_reg[k_reg] > best_reg[k_reg]);
        sts.lt       = (cur_reg[k_reg] < best_reg[k_reg]);
        sts.k_zero   = (k_reg == '0);
        sts.have     = have_reg;
        sts.p_last   = (p_reg == top_reg);
    end

    sfht_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_LEN)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (wp_reg),
        .wdata (stored),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_bin_reg  <= 10'd0;
            high_bin_reg <= 10'd512;
            mode_reg     <= 2'd3;
            thr_reg      <= 32'd0;
            bdef_reg     <= 32'd1;
            plo_reg      <= 11'd32;
            phi_reg      <= 11'd129;
            hc_reg       <= 4'd6;
            flux_reg     <= 32'd0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            start_reg    <= '0;
            h_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            p_reg        <= 11'd0;
            top_reg      <= 11'd0;
            have_reg     <= 1'b0;
            fail_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sfht_pkg::REG_LOW_BIN:          low_bin_reg  <= cfg_data[9:0];
                    sfht_pkg::REG_HIGH_BIN:         high_bin_reg <= cfg_data[9:0];
                    sfht_pkg::REG_MODE_FLAGS:       mode_reg     <= cfg_data[1:0];
                    sfht_pkg::REG_GROWTH_THRESHOLD: thr_reg      <= cfg_data;
                    sfht_pkg::REG_BELOW_DEFAULT:    bdef_reg     <= cfg_data;
                    sfht_pkg::REG_PERIOD_LOW:       plo_reg      <= cfg_data[10:0];
                    sfht_pkg::REG_PERIOD_HIGH:      phi_reg      <= cfg_data[10:0];
                    sfht_pkg::REG_HARMONIC_COUNT:   hc_reg       <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.acc)
            begin
                flux_reg <= cmd.frame ? 32'd0 : sum_sat;
            end
            if (cmd.store)
            begin
                wp_reg    <= (wp_reg == AW'(HISTORY_LEN - 1)) ? '0 : wp_reg + 1'b1;
                fill_reg  <= (fill_reg == HIST_N) ? fill_reg : fill_reg + 1'b1;
                start_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                start_reg <= start_reg + 1'b1;
            end
            if (cmd.setup)
            begin
                h_reg    <= h_clamp;
                p_reg    <= lo_eff;
                top_reg  <= top_eff;
                have_reg <= 1'b0;
                fail_reg <= 1'b0;
            end
            if (cmd.hdec)
            begin
                h_reg <= h_reg - 1'b1;
            end
            if (cmd.fail)
            begin
                fail_reg <= 1'b1;
            end
            if (cmd.pstart)
            begin
                j_reg <= HW'(1);
            end
            if (cmd.fac)
            begin
                k_reg <= '0;
            end
            if (cmd.mulb)
            begin
                if (sts.k_last)
                begin
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (cmd.kdec)
            begin
                k_reg <= k_reg - 1'b1;
            end
            if (cmd.copy)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.nextp)
            begin
                p_reg <= p_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame)
        begin
            frame_reg <= sum_sat;
        end
        if (cmd.scan_rd || cmd.ard)
        begin
            vld_reg <= ({1'b0, lk} >= (HIST_N - fill_reg));
        end
        if (cmd.ard)
        begin
            src_reg <= src_next;
        end
        if (cmd.idx)
        begin
            idx_reg <= IW'(p_reg) * IW'(j_reg);
        end
        if (cmd.pstart)
        begin
            cur_reg <= (MAX_HARMONICS * 32)'(1);
        end
        if (cmd.fac)
        begin
            carry_reg <= 32'd0;
            case (src_reg)
                SRC_RAM:  fac_reg <= rd_eff;
                SRC_DEF:  fac_reg <= bdef_reg;
                default:  fac_reg <= 32'd0;
            endcase
        end
        if (cmd.mula)
        begin
            prod_reg <= 64'(cur_reg[k_reg]) * 64'(fac_reg);
        end
        if (cmd.mulb)
        begin
            cur_reg[k_reg] <= mac[31:0];
            carry_reg      <= mac[63:32];
        end
        if (cmd.copy)
        begin
            best_reg   <= cur_reg;
            best_p_reg <= p_reg;
        end
    end

    assign period_frames = fail_reg ? 11'd0 : best_p_reg;
    assign found         = !fail_reg;
    assign frame_flux    = frame_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HIST_N)
        else $error("history fill count beyond depth");
    a_h_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hdec |=> h_reg >= HW'(2))
        else $error("harmonic count reduced below two");
    a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mula |-> k_reg <= K_TOP)
        else $error("product word index out of range");
`endif

endmodule

>>> hdl/spectral_flux_hps_tempo.sv
// Channel   Ports                                          Handshake
// request   now_mag prior_mag bin_number last_bin          start high, busy low
// result    period_frames found frame_flux                 done, one cycle
// config    cfg_index cfg_data                             cfg_write
//
// A bin without last_bin is accumulated while busy stays low.
// A last bin holds busy through an alignment scan, when enabled, that skips S entries,
// then R harmonic reductions and, for each of P periods, a product over H harmonics of
// M = MAX_HARMONICS words, C <= M compare steps and a copy when the period takes the lead;
// on failure it ends after the reductions. One shared 32x32 multiplier does the product.
// Reset clears control and sets default configuration; unwritten history entries read as zero.
module spectral_flux_hps_tempo #(
    parameter int HISTORY_LEN   = 1024,
    parameter int MAX_BIN       = 512,
    parameter int MAX_HARMONICS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [15:0]                         now_mag,
    input  logic [15:0]                         prior_mag,
    input  logic [9:0]                          bin_number,
    input  logic                                last_bin,
    output logic                                done,
    output logic [10:0]                         period_frames,
    output logic                                found,
    output logic [31:0]                         frame_flux,
    input  logic                                cfg_write,
    input  logic [sfht_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfht_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sfht_pkg::cmd_t cmd;
    sfht_pkg::sts_t sts;

    sfht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_bin (last_bin),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    sfht_dp #(
        .HISTORY_LEN   (HISTORY_LEN),
        .MAX_BIN       (MAX_BIN),
        .MAX_HARMONICS (MAX_HARMONICS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .now_mag       (now_mag),
        .prior_mag     (prior_mag),
        .bin_number    (bin_number),
        .period_frames (period_frames),
        .found         (found),
        .frame_flux    (frame_flux)
    );

endmodule
